[rtl/kvsp_pkg.sv]
`default_nettype none

package kvsp_pkg;

  localparam int VALUE_BITS_DEF = 32;

  localparam int NUM_NAMES  = 7;
  localparam int NUM_REQ    = 5;
  localparam int NAME_BYTES = 12;

  // name slots, in match priority order
  localparam logic [2:0] K_VERSION  = 3'd0;
  localparam logic [2:0] K_SEQUENCE = 3'd1;
  localparam logic [2:0] K_SHIFT    = 3'd2;
  localparam logic [2:0] K_SYM      = 3'd3;
  localparam logic [2:0] K_FN       = 3'd4;
  localparam logic [2:0] K_CHANGED  = 3'd5;
  localparam logic [2:0] K_REASON   = 3'd6;

  localparam logic [0:NUM_NAMES-1][0:NAME_BYTES-1][7:0] NAME_TEXT = {
    {"version",  40'h0},
    {"sequence", 32'h0},
    {"shift",    56'h0},
    {"sym",      72'h0},
    {"fn",       80'h0},
    {"changed",  "_mask"},
    {"reason",   48'h0}
  };

  localparam logic [0:NUM_NAMES-1][3:0] NAME_LEN = {
    4'd7, 4'd8, 4'd5, 4'd3, 4'd2, 4'd12, 4'd6
  };

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_MALFORMED = 3'd1;
  localparam logic [2:0] ERR_DUPLICATE = 3'd2;
  localparam logic [2:0] ERR_INVALID   = 3'd3;
  localparam logic [2:0] ERR_MODE      = 3'd4;
  localparam logic [2:0] ERR_MISSING   = 3'd5;
  localparam logic [2:0] ERR_VERSION   = 3'd6;

  localparam logic        REG_SUPPORTED_VERSION   = 1'b0;
  localparam logic [31:0] SUPPORTED_VERSION_RESET = 32'd1;

  typedef enum logic [1:0] {
    PH_GAP   = 2'd0,
    PH_NAME  = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  error_code;
    logic [31:0] version_value;
    logic [31:0] sequence_value;
    logic [2:0]  shift_mode;
    logic [2:0]  sym_mode;
    logic [2:0]  fn_mode;
    logic [7:0]  change_bits;
    logic        change_bits_present;
    logic [7:0]  reason_code;
    logic        reason_present;
  } out_t;

  function automatic logic [7:0] name_byte(logic [2:0] k, logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (32'(idx) < NAME_BYTES) begin
      b = NAME_TEXT[k][idx];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/key_value_snapshot_parser.sv]
// Streaming parser for a whitespace separated name=value text snapshot. One
// character is taken per item, the final one flagged by last_char; every
// character, including the final one, can be accepted on consecutive cycles.
// A character is held in the input register, and the scan logic updates the
// parse state from it as it leaves; a final character also writes the single
// result item to the output register, raising out_valid. The input side
// stalls only while a final character finds the output register still full.
// supported_version is written over the APB port at byte address 0; the user
// must do so only while the block is idle; the block does not enforce it.
`default_nettype none

module key_value_snapshot_parser #(
  parameter int VALUE_BITS = kvsp_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire kvsp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output kvsp_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic           hold_valid;
  kvsp_pkg::in_t  hold_item;
  logic           advance;
  logic [31:0]    supported_version;
  kvsp_pkg::out_t scan_result;

  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == kvsp_pkg::REG_SUPPORTED_VERSION) ? supported_version : '0;

  assign advance  = hold_valid && (!hold_item.last_char || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      supported_version <= kvsp_pkg::SUPPORTED_VERSION_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == kvsp_pkg::REG_SUPPORTED_VERSION) begin
      supported_version <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  kvsp_scan #(
    .VALUE_BITS(VALUE_BITS)
  ) u_scan (
    .clk               (clk),
    .rst               (rst),
    .step              (advance),
    .item              (hold_item),
    .supported_version (supported_version),
    .result            (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_item.last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_item.last_char) begin
      out_data <= scan_result;
    end
  end

endmodule

`default_nettype wire

[rtl/kvsp_scan.sv]
`default_nettype none

module kvsp_scan #(
  parameter int VALUE_BITS = kvsp_pkg::VALUE_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire kvsp_pkg::in_t  item,
  input  wire logic [31:0]    supported_version,
  output kvsp_pkg::out_t      result
);

  localparam int PW    = VALUE_BITS + 4;
  localparam int CMP_W = (VALUE_BITS > 32) ? VALUE_BITS : 32;
  localparam logic [VALUE_BITS-1:0] MODE_MAX = VALUE_BITS'(4);
  localparam logic [VALUE_BITS-1:0] BYTE_MAX = VALUE_BITS'(255);
  localparam logic [7:0] CH_EQ = 8'h3D;

  kvsp_pkg::phase_t                 phase, upd_phase, phase_next;
  logic [kvsp_pkg::NUM_NAMES-1:0]   cand, upd_cand, cand_next;
  logic [3:0]                       nlen, upd_nlen, nlen_next;
  logic [1:0]                       vlen, upd_vlen, vlen_next;
  logic                             hexm, upd_hexm, hexm_next;
  logic [VALUE_BITS-1:0]            acc, upd_acc, acc_next;
  logic                             inv, upd_inv, inv_next;
  logic [kvsp_pkg::NUM_REQ-1:0]     seen, upd_seen, seen_next;
  logic [VALUE_BITS-1:0]            sver, upd_sver, sver_next;
  logic [VALUE_BITS-1:0]            sseq, upd_sseq, sseq_next;
  logic [2:0][2:0]                  smode, upd_smode, smode_next;
  logic [8:0]                       schg, upd_schg, schg_next;
  logic [8:0]                       srsn, upd_srsn, srsn_next;
  logic [2:0]                       err, upd_err, err_next;

  always_comb begin
    logic       space;
    logic       do_finish;
    logic       valid;
    logic       found;
    logic [2:0] kk;
    logic       dig_ok;
    logic [3:0] dval;
    logic [PW-1:0] prod;
    logic [7:0] c;

    c         = item.char_byte;
    space     = c inside {8'h20, [8'h09:8'h0D]};
    do_finish = 1'b0;
    found     = 1'b0;
    kk        = '0;
    valid     = 1'b0;
    dig_ok    = 1'b0;
    dval      = '0;
    prod      = '0;

    upd_phase = phase;
    upd_cand  = cand;
    upd_nlen  = nlen;
    upd_vlen  = vlen;
    upd_hexm  = hexm;
    upd_acc   = acc;
    upd_inv   = inv;
    upd_seen  = seen;
    upd_sver  = sver;
    upd_sseq  = sseq;
    upd_smode = smode;
    upd_schg  = schg;
    upd_srsn  = srsn;
    upd_err   = err;

    if (step && err == kvsp_pkg::ERR_NONE) begin
      if (upd_phase == kvsp_pkg::PH_GAP && !space) begin
        upd_phase = kvsp_pkg::PH_NAME;
        upd_cand  = '1;
        upd_nlen  = '0;
      end
      if (upd_phase == kvsp_pkg::PH_NAME && !space && c != CH_EQ) begin
        for (int k = 0; k < kvsp_pkg::NUM_NAMES; k++) begin
          if (upd_cand[k] && (upd_nlen >= kvsp_pkg::NAME_LEN[k] ||
              kvsp_pkg::name_byte(3'(k), upd_nlen) != c)) begin
            upd_cand[k] = 1'b0;
          end
        end
        if (upd_nlen != 4'd15) begin
          upd_nlen = upd_nlen + 4'd1;
        end
      end else if (upd_phase == kvsp_pkg::PH_NAME && space) begin
        upd_err = kvsp_pkg::ERR_MALFORMED;
      end else if (upd_phase == kvsp_pkg::PH_NAME) begin
        if (upd_nlen == 4'd0) begin
          upd_err = kvsp_pkg::ERR_MALFORMED;
        end else begin
          for (int k = 0; k < kvsp_pkg::NUM_NAMES; k++) begin
            if (kvsp_pkg::NAME_LEN[k] != upd_nlen) begin
              upd_cand[k] = 1'b0;
            end
          end
          upd_phase = kvsp_pkg::PH_VALUE;
          upd_vlen  = '0;
          upd_hexm  = 1'b0;
          upd_acc   = '0;
          upd_inv   = 1'b0;
        end
      end else if (upd_phase == kvsp_pkg::PH_VALUE) begin
        if (space) begin
          do_finish = 1'b1;
          upd_phase = kvsp_pkg::PH_GAP;
        end else begin
          if (c inside {["0":"9"]}) begin
            dig_ok = 1'b1;
            dval   = 4'(c - "0");
          end else if (c inside {["a":"f"]}) begin
            dig_ok = upd_hexm;
            dval   = 4'(c - "a" + 8'd10);
          end else if (c inside {["A":"F"]}) begin
            dig_ok = upd_hexm;
            dval   = 4'(c - "A" + 8'd10);
          end
          if (upd_vlen == 2'd1 && !upd_hexm && !upd_inv && upd_acc == '0 &&
              (c == "x" || c == "X")) begin
            upd_hexm = 1'b1;
          end else if (!dig_ok) begin
            upd_inv = 1'b1;
          end else begin
            prod = upd_hexm ? {upd_acc, 4'h0}
                            : ({1'b0, upd_acc, 3'h0} + {3'h0, upd_acc, 1'b0});
            prod = prod + PW'(dval);
            if (prod[PW-1:VALUE_BITS] != '0) begin
              upd_inv = 1'b1;
            end else begin
              upd_acc = prod[VALUE_BITS-1:0];
            end
          end
          if (upd_vlen != 2'd3) begin
            upd_vlen = upd_vlen + 2'd1;
          end
        end
      end
    end

    // close a pending token at end of text
    if (step && item.last_char && upd_err == kvsp_pkg::ERR_NONE) begin
      if (upd_phase == kvsp_pkg::PH_NAME) begin
        upd_err = kvsp_pkg::ERR_MALFORMED;
      end else if (upd_phase == kvsp_pkg::PH_VALUE) begin
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      valid = !upd_inv && upd_vlen != 2'd0 && !(upd_hexm && upd_vlen == 2'd2);
      for (int k = 0; k < kvsp_pkg::NUM_NAMES; k++) begin
        if (upd_cand[k] && !found) begin
          found = 1'b1;
          kk    = 3'(k);
        end
      end
      if (found) begin
        if (kk < 3'(kvsp_pkg::NUM_REQ)) begin
          if (upd_seen[kk]) begin
            upd_err = kvsp_pkg::ERR_DUPLICATE;
          end else if (!valid) begin
            upd_err = kvsp_pkg::ERR_INVALID;
          end else begin
            upd_seen[kk] = 1'b1;
            case (kk)
              kvsp_pkg::K_VERSION:  upd_sver = upd_acc;
              kvsp_pkg::K_SEQUENCE: upd_sseq = upd_acc;
              default: begin
                if (upd_acc > MODE_MAX) begin
                  upd_err = kvsp_pkg::ERR_MODE;
                end else begin
                  case (kk)
                    kvsp_pkg::K_SHIFT: upd_smode[0] = upd_acc[2:0];
                    kvsp_pkg::K_SYM:   upd_smode[1] = upd_acc[2:0];
                    default:           upd_smode[2] = upd_acc[2:0];
                  endcase
                end
              end
            endcase
          end
        end else begin
          if (!valid || upd_acc > BYTE_MAX) begin
            upd_err = kvsp_pkg::ERR_INVALID;
          end else if (kk == kvsp_pkg::K_CHANGED) begin
            upd_schg = {1'b1, upd_acc[7:0]};
          end else begin
            upd_srsn = {1'b1, upd_acc[7:0]};
          end
        end
      end
    end

    if (step && item.last_char && upd_err == kvsp_pkg::ERR_NONE) begin
      if (upd_seen != '1) begin
        upd_err = kvsp_pkg::ERR_MISSING;
      end else if (CMP_W'(upd_sver) != CMP_W'(supported_version)) begin
        upd_err = kvsp_pkg::ERR_VERSION;
      end
    end
  end

  // back to a clean parse after the final character
  always_comb begin
    if (step && item.last_char) begin
      phase_next = kvsp_pkg::PH_GAP;
      cand_next  = '1;
      nlen_next  = '0;
      vlen_next  = '0;
      hexm_next  = 1'b0;
      acc_next   = '0;
      inv_next   = 1'b0;
      seen_next  = '0;
      sver_next  = '0;
      sseq_next  = '0;
      smode_next = '0;
      schg_next  = '0;
      srsn_next  = '0;
      err_next   = kvsp_pkg::ERR_NONE;
    end else begin
      phase_next = upd_phase;
      cand_next  = upd_cand;
      nlen_next  = upd_nlen;
      vlen_next  = upd_vlen;
      hexm_next  = upd_hexm;
      acc_next   = upd_acc;
      inv_next   = upd_inv;
      seen_next  = upd_seen;
      sver_next  = upd_sver;
      sseq_next  = upd_sseq;
      smode_next = upd_smode;
      schg_next  = upd_schg;
      srsn_next  = upd_srsn;
      err_next   = upd_err;
    end
  end

  always_comb begin
    result            = '0;
    result.error_code = upd_err;
    if (upd_err == kvsp_pkg::ERR_NONE) begin
      result.ok                  = 1'b1;
      result.version_value       = 32'(upd_sver);
      result.sequence_value      = 32'(upd_sseq);
      result.shift_mode          = upd_smode[0];
      result.sym_mode            = upd_smode[1];
      result.fn_mode             = upd_smode[2];
      result.change_bits         = upd_schg[7:0];
      result.change_bits_present = upd_schg[8];
      result.reason_code         = upd_srsn[7:0];
      result.reason_present      = upd_srsn[8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= kvsp_pkg::PH_GAP;
      cand  <= '1;
      nlen  <= '0;
      vlen  <= '0;
      hexm  <= 1'b0;
      acc   <= '0;
      inv   <= 1'b0;
      seen  <= '0;
      sver  <= '0;
      sseq  <= '0;
      smode <= '0;
      schg  <= '0;
      srsn  <= '0;
      err   <= kvsp_pkg::ERR_NONE;
    end else begin
      phase <= phase_next;
      cand  <= cand_next;
      nlen  <= nlen_next;
      vlen  <= vlen_next;
      hexm  <= hexm_next;
      acc   <= acc_next;
      inv   <= inv_next;
      seen  <= seen_next;
      sver  <= sver_next;
      sseq  <= sseq_next;
      smode <= smode_next;
      schg  <= schg_next;
      srsn  <= srsn_next;
      err   <= err_next;
    end
  end

endmodule

`default_nettype wire
